>>> hdl/sabs_pkg.sv
// Package for the sorted array binary search block.
// Holds default parameters, the queued command type and the operation codes.
// No dependencies.
package sabs_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int POS_W          = 12;
  localparam int WIDX_W         = 10;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_EXACT,
    OP_FIRST_GE,
    OP_LAST_LE,
    OP_NONE
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef struct packed {
    op_t                op;
    logic [WIDX_W-1:0]  widx;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
  } cmd_t;

endpackage

>>> hdl/sorted_array_binary_search.sv
// Top level of the sorted array binary search block.
// Joins the front classifier, the command queue and the search back end.
// Depends on sabs_pkg, sabs_front, sabs_fifo, sabs_back.
//
//   channel  handshake            payload
//   in       start / busy         in_kind .. in_range_high
//   out      out_strobe (1 cycle) out_result_index
//
// A write is done in the back end as it is popped; a search runs one halving
// probe per cycle through the registered store read feeding the next midpoint.
// busy rises while the two-entry command queue is full. Results cannot be held
// off. Reset clears control only; the store stays undefined until written.
module sorted_array_binary_search #(
  parameter int DEPTH      = sabs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sabs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [9:0]         in_write_index,
  input  logic signed [31:0] in_write_value,
  input  logic [1:0]         in_search_mode,
  input  logic signed [31:0] in_target,
  input  logic [10:0]        in_range_low,
  input  logic [10:0]        in_range_high,
  output logic               out_strobe,
  output logic [11:0]        out_result_index
);
  import sabs_pkg::*;

  localparam int QW = $bits(cmd_t) + VALUE_BITS;

  logic                         push, pop, empty, full;
  cmd_t                         f_cmd, h_cmd;
  logic signed [VALUE_BITS-1:0] f_value, h_value;
  logic [QW-1:0]                head;

  assign busy = full;

  sabs_front #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_front (
    .accept         (start && !busy),
    .in_kind        (in_kind),
    .in_write_index (in_write_index),
    .in_write_value (in_write_value),
    .in_search_mode (in_search_mode),
    .in_target      (in_target),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .push           (push),
    .cmd            (f_cmd),
    .value          (f_value)
  );

  sabs_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_value}),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  assign h_cmd   = head[QW-1:VALUE_BITS];
  assign h_value = head[VALUE_BITS-1:0];

  sabs_back #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (!empty),
    .head_cmd         (h_cmd),
    .head_value       (h_value),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_result_index (out_result_index)
  );

endmodule

>>> hdl/sabs_front.sv
// Front part: classifies an accepted word into a queued command.
// Clamps the search range, wraps values and drops writes beyond the store.
// Depends on sabs_pkg.
module sabs_front #(
  parameter int DEPTH      = sabs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sabs_pkg::VALUE_BITS_DEF
) (
  input  logic                         accept,
  input  logic                         in_kind,
  input  logic [9:0]                   in_write_index,
  input  logic signed [31:0]           in_write_value,
  input  logic [1:0]                   in_search_mode,
  input  logic signed [31:0]           in_target,
  input  logic [10:0]                  in_range_low,
  input  logic [10:0]                  in_range_high,
  output logic                         push,
  output sabs_pkg::cmd_t               cmd,
  output logic signed [VALUE_BITS-1:0] value
);
  import sabs_pkg::*;

  logic [POS_W-1:0] hi_c;
  logic [POS_W-1:0] lo_c;
  logic             keep;

  always_comb begin
    hi_c = (32'(in_range_high) > DEPTH) ? POS_W'(DEPTH) : {1'b0, in_range_high};
    lo_c = ({1'b0, in_range_low} > hi_c) ? hi_c : {1'b0, in_range_low};
    cmd.widx = in_write_index;
    cmd.lo   = lo_c;
    cmd.hi   = hi_c;
    keep     = 1'b1;
    if (!in_kind) begin
      cmd.op = OP_WRITE;
      keep   = (32'(in_write_index) < DEPTH);
      value  = VALUE_BITS'(in_write_value);
    end else begin
      value = VALUE_BITS'(in_target);
      unique case (in_search_mode)
        2'd0: cmd.op = OP_EXACT;
        2'd1: cmd.op = OP_FIRST_GE;
        2'd2: cmd.op = OP_LAST_LE;
        2'd3: cmd.op = OP_NONE;
      endcase
    end
    push = accept && keep;
  end

endmodule

>>> hdl/sabs_fifo.sv
// Short command queue between the front and back parts.
// Generic width; depth from the package.
// Depends on sabs_pkg.
module sabs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);
  import sabs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_nxt  = push ? bump(wr_r) : wr_r;
    rd_nxt  = pop ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
    head    = slot_r[rd_r];
    empty   = (cnt_r == '0);
    full    = (32'(cnt_r) == QUEUE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

>>> hdl/sabs_back.sv
// Back part: holds the store, runs writes and halving searches, drives results.
// One probe per cycle through the registered store read.
// Depends on sabs_pkg.
module sabs_back #(
  parameter int DEPTH      = sabs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = sabs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  sabs_pkg::cmd_t               head_cmd,
  input  logic signed [VALUE_BITS-1:0] head_value,
  output logic                         pop,
  output logic                         out_strobe,
  output logic [11:0]                  out_result_index
);
  import sabs_pkg::*;

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];

  st_t                          st_r, st_nxt;
  op_t                          op_r, op_nxt;
  logic signed [VALUE_BITS-1:0] tgt_r, tgt_nxt;
  logic signed [VALUE_BITS-1:0] rdata_r;
  logic signed [POS_W-1:0]      p_r, p_nxt, q_r, q_nxt, mid_r, mid_nxt;
  logic                         strobe_r, strobe_nxt;
  logic signed [POS_W-1:0]      res_r, res_nxt;
  logic                         we, go, fin;

  function automatic logic cond_f(input op_t op, input logic signed [POS_W-1:0] p,
                                  input logic signed [POS_W-1:0] q);
    unique case (op)
      OP_EXACT:    cond_f = (p <= q);
      OP_FIRST_GE: cond_f = ((p + POS_W'(1)) != q);
      OP_LAST_LE:  cond_f = (p < q);
      default:     cond_f = 1'b0;
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] final_f(input op_t op,
                                                      input logic signed [POS_W-1:0] p,
                                                      input logic signed [POS_W-1:0] q);
    unique case (op)
      OP_FIRST_GE: final_f = q;
      OP_LAST_LE:  final_f = p - POS_W'(1);
      default:     final_f = -POS_W'(1);
    endcase
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (go) st_nxt = ST_RUN;
      ST_RUN:  if (fin) st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    we         = 1'b0;
    go         = 1'b0;
    fin        = 1'b0;
    op_nxt     = op_r;
    tgt_nxt    = tgt_r;
    p_nxt      = p_r;
    q_nxt      = q_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    unique case (st_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop     = 1'b1;
          op_nxt  = head_cmd.op;
          tgt_nxt = head_value;
          p_nxt   = $signed(head_cmd.lo);
          q_nxt   = $signed(head_cmd.hi);
          unique case (head_cmd.op)
            OP_WRITE:    we = 1'b1;
            OP_EXACT:    q_nxt = $signed(head_cmd.hi) - POS_W'(1);
            OP_FIRST_GE: p_nxt = $signed(head_cmd.lo) - POS_W'(1);
            default: ;
          endcase
          if (head_cmd.op != OP_WRITE) begin
            if (cond_f(head_cmd.op, p_nxt, q_nxt)) begin
              go = 1'b1;
            end else begin
              strobe_nxt = 1'b1;
              res_nxt    = final_f(head_cmd.op, p_nxt, q_nxt);
            end
          end
        end
      end
      ST_RUN: begin
        unique case (op_r)
          OP_EXACT: begin
            if (rdata_r < tgt_r) p_nxt = mid_r + POS_W'(1);
            else if (rdata_r > tgt_r) q_nxt = mid_r - POS_W'(1);
          end
          OP_FIRST_GE: begin
            if (rdata_r < tgt_r) p_nxt = mid_r;
            else q_nxt = mid_r;
          end
          default: begin
            if (tgt_r < rdata_r) q_nxt = mid_r;
            else p_nxt = mid_r + POS_W'(1);
          end
        endcase
        if (op_r == OP_EXACT && rdata_r == tgt_r) begin
          fin        = 1'b1;
          strobe_nxt = 1'b1;
          res_nxt    = mid_r;
        end else if (!cond_f(op_r, p_nxt, q_nxt)) begin
          fin        = 1'b1;
          strobe_nxt = 1'b1;
          res_nxt    = final_f(op_r, p_nxt, q_nxt);
        end
      end
    endcase
    mid_nxt = p_nxt + ((q_nxt - p_nxt) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r  <= op_nxt;
    tgt_r <= tgt_nxt;
    p_r   <= p_nxt;
    q_r   <= q_nxt;
    mid_r <= mid_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(head_cmd.widx)] <= head_value;
    end
    rdata_r <= mem[AW'($unsigned(mid_nxt))];
  end

  assign out_strobe       = strobe_r;
  assign out_result_index = res_r;

`ifndef NO_ASSERTIONS
  a_run_op : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (op_r == OP_EXACT || op_r == OP_FIRST_GE || op_r == OP_LAST_LE))
    else $error("search running with a non-search command");
  a_mid_in : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (mid_r >= p_r && mid_r <= q_r))
    else $error("probe outside the search window");
  a_run_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (!pop && !we))
    else $error("queue popped or store written during a search");
  a_fin_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && fin) |=> (out_strobe && st_r == ST_IDLE))
    else $error("finished search gave no result");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for sorted_array_binary_search: drives write and search words,
// predicts each search index by its own halving over a shadow store and checks every result.
// Depends on sabs_pkg and the sorted_array_binary_search RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = sabs_pkg::DEPTH_DEF;
  localparam int ITEMS       = 1500;
  localparam int SETTLE      = 60;
  localparam int STALL_LIMIT = 2000;

  localparam logic       KIND_WRITE    = 1'b0;
  localparam logic       KIND_SEARCH   = 1'b1;
  localparam logic [1:0] MODE_EXACT    = 2'd0;
  localparam logic [1:0] MODE_FIRST_GE = 2'd1;
  localparam logic [1:0] MODE_LAST_LE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic        kind;
    logic [9:0]  widx;
    logic [31:0] wval;
    logic [1:0]  mode;
    logic [31:0] tgt;
    logic [10:0] lo;
    logic [10:0] hi;
  } cmd_word_t;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               start            = 1'b0;
  logic               busy;
  logic               in_kind          = 1'b0;
  logic [9:0]         in_write_index   = '0;
  logic signed [31:0] in_write_value   = '0;
  logic [1:0]         in_search_mode   = '0;
  logic signed [31:0] in_target        = '0;
  logic [10:0]        in_range_low     = '0;
  logic [10:0]        in_range_high    = '0;
  logic               out_strobe;
  logic [11:0]        out_result_index;

  sorted_array_binary_search u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_write_index   (in_write_index),
    .in_write_value   (in_write_value),
    .in_search_mode   (in_search_mode),
    .in_target        (in_target),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .out_strobe       (out_strobe),
    .out_result_index (out_result_index)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cmd_word_t   pending_words[$];
  logic [11:0] expected_index[$];
  cmd_word_t   next_word;
  logic [11:0] want_index;

  int store_val   [DEPTH];
  int gen_val     [DEPTH];
  bit gen_written [DEPTH];

  int n_sent       = 0;
  int n_writes     = 0;
  int n_searches   = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int stall_cycles = 0;
  int total_words  = 0;
  int mode_cnt [4];
  logic calm;

  assign calm = (n_sent >= 600) && (n_sent < 900);

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("tb_top: mismatch: %s", msg);
  endtask

  // Halving search over the shadow store, same probe order as the block.
  function automatic logic [11:0] locate_index(logic [1:0] mode, int tgt, int lo_raw,
                                               int hi_raw);
    int lo, hi, a, b, m, r;
    hi = (hi_raw > DEPTH) ? DEPTH : hi_raw;
    lo = (lo_raw > hi) ? hi : lo_raw;
    r  = -1;
    case (mode)
      MODE_EXACT: begin
        a = lo;
        b = hi - 1;
        while (a <= b && r < 0) begin
          m = a + ((b - a) >>> 1);
          if (store_val[m] < tgt) a = m + 1;
          else if (store_val[m] > tgt) b = m - 1;
          else r = m;
        end
      end
      MODE_FIRST_GE: begin
        a = lo - 1;
        b = hi;
        while (a + 1 != b) begin
          m = a + ((b - a) >>> 1);
          if (store_val[m] < tgt) a = m;
          else b = m;
        end
        r = b;
      end
      MODE_LAST_LE: begin
        a = lo;
        b = hi;
        while (a < b) begin
          m = a + ((b - a) >>> 1);
          if (tgt < store_val[m]) b = m;
          else a = m + 1;
        end
        r = a - 1;
      end
      default: r = -1;
    endcase
    return r[11:0];
  endfunction

  task automatic push_write(input int idx, input int val);
    cmd_word_t w;
    w.kind = KIND_WRITE;
    w.widx = idx[9:0];
    w.wval = val;
    w.mode = 2'($urandom);
    w.tgt  = $urandom;
    w.lo   = 11'($urandom);
    w.hi   = 11'($urandom);
    pending_words.push_back(w);
    gen_val[idx]     = val;
    gen_written[idx] = 1'b1;
  endtask

  task automatic push_search(input logic [1:0] mode, input logic [31:0] tgt, input int lo,
                             input int hi);
    cmd_word_t w;
    w.kind = KIND_SEARCH;
    w.widx = 10'($urandom);
    w.wval = $urandom;
    w.mode = mode;
    w.tgt  = tgt;
    w.lo   = lo[10:0];
    w.hi   = hi[10:0];
    pending_words.push_back(w);
  endtask

  // Driver: account for the accepted word, then load the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (in_kind == KIND_WRITE) begin
          store_val[in_write_index] = in_write_value;
          n_writes++;
        end else begin
          expected_index.push_back(locate_index(in_search_mode, in_target, in_range_low,
                                                in_range_high));
          n_searches++;
          mode_cnt[in_search_mode]++;
        end
        n_sent++;
      end
      if (!start || !busy) begin
        if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          next_word = pending_words.pop_front();
          start          <= 1'b1;
          in_kind        <= next_word.kind;
          in_write_index <= next_word.widx;
          in_write_value <= next_word.wval;
          in_search_mode <= next_word.mode;
          in_target      <= next_word.tgt;
          in_range_low   <= next_word.lo;
          in_range_high  <= next_word.hi;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed index with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_index.size() == 0) begin
        flag_mismatch($sformatf("index %0d with no search pending", $signed(out_result_index)));
      end else begin
        want_index = expected_index.pop_front();
        n_checked++;
        if (out_result_index !== want_index)
          flag_mismatch($sformatf("search %0d: got index %0d, want %0d", n_checked,
                                  $signed(out_result_index), $signed(want_index)));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int          base, len, k, p, a, b, lo, hi, hi_e, lo_e, nsearch, step;
    longint      cur;
    logic [1:0]  mode;
    logic [31:0] tgt;
    bit          ok;

    // Directed: extremes, duplicates, every mode, empty and clamped ranges.
    push_write(0, VAL_MIN);
    push_write(1, -5);
    push_write(2, 0);
    push_write(3, 0);
    push_write(4, 7);
    push_write(5, VAL_MAX);
    push_write(1020, 100);
    push_write(1021, 200);
    push_write(1022, 200);
    push_write(1023, VAL_MAX);
    push_search(MODE_EXACT, 0, 0, 6);
    push_search(MODE_EXACT, 3, 0, 6);
    push_search(MODE_FIRST_GE, VAL_MIN, 0, 6);
    push_search(MODE_FIRST_GE, VAL_MAX, 0, 6);
    push_search(MODE_LAST_LE, VAL_MIN, 0, 6);
    push_search(MODE_LAST_LE, VAL_MAX, 0, 6);
    push_search(MODE_LAST_LE, -6, 0, 6);
    push_search(MODE_FIRST_GE, 8, 0, 5);
    push_search(MODE_EXACT, 0, 3, 3);
    push_search(MODE_FIRST_GE, 0, 3, 3);
    push_search(MODE_LAST_LE, 0, 3, 3);
    push_search(MODE_FIRST_GE, 0, 1500, 2047);
    push_search(MODE_LAST_LE, VAL_MAX, 1020, 2047);
    push_search(MODE_EXACT, 200, 1020, 2047);
    push_search(MODE_UNUSED, 0, 0, 6);
    push_search(MODE_LAST_LE, 0, 2047, 0);

    // Random: fill a sorted run, then search inside written spans.
    while (pending_words.size() < ITEMS) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(2, 40);
      base = $urandom_range(0, DEPTH - len);
      case ($urandom_range(0, 3))
        0:       cur = VAL_MIN;
        1:       cur = longint'($urandom_range(0, 200)) - 100;
        default: cur = longint'($signed($urandom));
      endcase
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) push_write($urandom_range(0, DEPTH - 1), $urandom);
        push_write(base + k, int'(cur));
        if ($urandom_range(0, 3) != 0) begin
          step = $urandom_range(1, 1 << $urandom_range(0, 24));
          cur += step;
        end
        if (cur > VAL_MAX) cur = VAL_MAX;
      end
      nsearch = $urandom_range(3, 12);
      for (k = 0; k < nsearch; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          lo   = $urandom_range(0, 2047);
          hi   = $urandom_range(0, 2047);
          hi_e = (hi > DEPTH) ? DEPTH : hi;
          lo_e = (lo > hi_e) ? hi_e : lo;
          ok   = 1'b1;
          for (p = lo_e; p < hi_e; p++) if (!gen_written[p]) ok = 1'b0;
          if (!ok) lo = $urandom_range(hi, 2047);
          push_search(2'($urandom_range(0, 3)), $urandom, lo, hi);
        end else begin
          if ($urandom_range(0, 9) < 7) begin
            a = base;
            b = base + len;
          end else begin
            p = $urandom_range(0, DEPTH - 1);
            a = p;
            while (a > 0 && gen_written[a - 1]) a--;
            b = p;
            while (b < DEPTH && gen_written[b]) b++;
          end
          lo = $urandom_range(a, b);
          hi = $urandom_range(lo, b);
          if (hi == DEPTH && $urandom_range(0, 1) == 1) hi = $urandom_range(DEPTH, 2047);
          hi_e = (hi > DEPTH) ? DEPTH : hi;
          mode = ($urandom_range(0, 29) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
          p    = (hi_e > lo) ? $urandom_range(lo, hi_e - 1) : -1;
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: tgt = (p >= 0) ? gen_val[p] : $urandom;
            5, 6:          tgt = (p >= 0) ? gen_val[p] + ($urandom_range(0, 1) ? 1 : -1)
                                          : $urandom;
            7:             tgt = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
            default:       tgt = $urandom;
          endcase
          push_search(mode, tgt, lo, hi);
        end
      end
    end
    total_words = pending_words.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == total_words);
    wait (expected_index.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("tb_top: %0d words sent: %0d writes, %0d searches (exact %0d, first-ge %0d,",
             n_sent, n_writes, n_searches, mode_cnt[MODE_EXACT], mode_cnt[MODE_FIRST_GE]);
    $display("tb_top: last-le %0d, unused mode %0d); %0d indexes checked, %0d mismatches",
             mode_cnt[MODE_LAST_LE], mode_cnt[MODE_UNUSED], n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
